// ===== hw/rtl/keyframe_luminance_lerp_xyz_to_rgb_macros.svh =====
// assertion helpers shared by the top-level and kflerp_interp rtl files
`ifndef KEYFRAME_LUMINANCE_LERP_XYZ_TO_RGB_MACROS_SVH
`define KEYFRAME_LUMINANCE_LERP_XYZ_TO_RGB_MACROS_SVH

// same-cycle implication, checked out of reset
`define KFLERP_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KFLERP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/kflerp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kflerp_pkg;

  // field widths
  localparam int HOUR_W     = 16;
  localparam int HOUR_FRAC  = 11;
  localparam int OUT_W      = 24;
  localparam int OUT_FIELDS = 9;
  localparam int DATA_OUT_W = OUT_FIELDS * OUT_W;

  // keyframe rom sizes and default settings
  localparam int SUN_ROM       = 14;
  localparam int SKY_ROM       = 18;
  localparam int SUN_KEYS_DEF  = 14;
  localparam int SKY_KEYS_DEF  = 18;
  localparam int FRAC_BITS_DEF = 12;

  // interpolation: widest span is four hours, so the offset needs 13 bits
  localparam int T_W  = 13;
  localparam int SH_W = 4;

  // matrix coefficients are in millionths
  localparam int    C_W        = 23;
  localparam longint MICRO      = 64'sd1000000;
  localparam longint HALF_MICRO = MICRO / 2;

  // output saturation
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // rounded magnitudes at or above this saturate in either direction
  localparam longint SAT_CAP = ((64'sd1 <<< (OUT_W - 1)) + 64'sd1) * MICRO;
  localparam int     CAP_W   = 44;

  // divide by 1e6: drop 2^6 first, then multiply by a reciprocal of 15625
  localparam int     DIV_PRE_SH = 6;
  localparam longint DIV_ODD    = MICRO / (64'sd1 <<< DIV_PRE_SH);
  localparam int     DQ_W       = 37;
  localparam int     RECIP_SH   = 51;
  localparam longint RECIP      = ((64'sd1 <<< RECIP_SH) + DIV_ODD - 64'sd1) / DIV_ODD;
  localparam int     RECIP_W    = 38;
  localparam int     PP_LO_W    = 19;
  localparam int     DQ_HI_W    = DQ_W - PP_LO_W;
  localparam int     RC_HI_W    = RECIP_W - PP_LO_W;
  localparam int     FULL_W     = DQ_W + RECIP_W + 1;
  localparam int     QUOT_W     = 24;

  function automatic int pick3(int c, int a, int b, int d);
    return (c == 0) ? a : ((c == 1) ? b : d);
  endfunction

  // key positions in whole hours
  function automatic int key_hour(bit is_sky, int i);
    int h;
    h = 0;
    if (is_sky) begin
      case (i)
        0: h = 0;   1: h = 4;   2: h = 5;   3: h = 7;   4: h = 8;   5: h = 9;
        6: h = 10;  7: h = 11;  8: h = 12;  9: h = 13;  10: h = 14; 11: h = 15;
        12: h = 16; 13: h = 17; 14: h = 18; 15: h = 20; 16: h = 21; 17: h = 23;
        default: h = 0;
      endcase
    end else begin
      case (i)
        0: h = 5;   1: h = 7;   2: h = 8;   3: h = 9;   4: h = 10;  5: h = 11;
        6: h = 12;  7: h = 13;  8: h = 14;  9: h = 15;  10: h = 16; 11: h = 17;
        12: h = 18; 13: h = 20;
        default: h = 0;
      endcase
    end
    return h;
  endfunction

  // keyframe xyz values in millionths
  function automatic int sun_val(int i, int c);
    int v;
    case (i)
      1:  v = pick3(c, 12703322, 12989393, 9100411);
      2:  v = pick3(c, 13202644, 13597814, 11524929);
      3:  v = pick3(c, 13192974, 13597458, 12264488);
      4:  v = pick3(c, 13132943, 13535914, 12560032);
      5:  v = pick3(c, 13088722, 13489535, 12692996);
      6:  v = pick3(c, 13067827, 13467483, 12745179);
      7:  v = pick3(c, 13069653, 13469413, 12740822);
      8:  v = pick3(c, 13094319, 13495428, 12678066);
      9:  v = pick3(c, 13142133, 13545483, 12526785);
      10: v = pick3(c, 13201734, 13606017, 12188001);
      11: v = pick3(c, 13182774, 13572725, 11311157);
      12: v = pick3(c, 12448635, 12672520, 8267771);
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic int sky_val(int i, int c);
    int v;
    case (i)
      1:  v = pick3(c, 12900, 12900, 17200);
      2:  v = pick3(c, 258000, 258000, 344000);
      3:  v = pick3(c, 962851, 1000000, 1747835);
      4:  v = pick3(c, 967787, 1000000, 1776762);
      5:  v = pick3(c, 970173, 1000000, 1788413);
      6:  v = pick3(c, 971431, 1000000, 1794102);
      7:  v = pick3(c, 972099, 1000000, 1797096);
      8:  v = pick3(c, 972385, 1000000, 1798389);
      9:  v = pick3(c, 972361, 1000000, 1798278);
      10: v = pick3(c, 972020, 1000000, 1796740);
      11: v = pick3(c, 971275, 1000000, 1793407);
      12: v = pick3(c, 969885, 1000000, 1787078);
      13: v = pick3(c, 967216, 1000000, 1773758);
      14: v = pick3(c, 961668, 1000000, 1739891);
      15: v = pick3(c, 264000, 264000, 352000);
      16: v = pick3(c, 13200, 13200, 17600);
      default: v = 0;
    endcase
    return v;
  endfunction

  // millionths to fixed point, rounded half away from zero
  function automatic longint to_fixed(longint micro, int frac);
    longint n;
    n = micro * (64'sd1 <<< frac);
    if (n < 0) return -((-n + HALF_MICRO) / MICRO);
    return (n + HALF_MICRO) / MICRO;
  endfunction

  // log2 of the span from key i to key i+1, in input lsbs
  function automatic int span_shift(bit is_sky, int i, int rom);
    int d;
    if (i >= rom - 1) return HOUR_FRAC;
    d = key_hour(is_sky, i + 1) - key_hour(is_sky, i);
    return HOUR_FRAC + $clog2(d);
  endfunction

  // xyz to rgb matrix, rows r g b, columns x y z, in millionths
  function automatic int mat_coef(int r, int c);
    int v;
    case (r)
      0: v = pick3(c, 3240479, -1537150, -498530);
      1: v = pick3(c, -969256, 1875991, 41556);
      default: v = pick3(c, 55648, -204043, 1057311);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/keyframe_luminance_lerp_xyz_to_rgb.sv =====
// throughput: one word per cycle unless a result is stalled; 4 interpolation stages, then 5 matrix and divide stages
// a stalled result (m_tvalid high, m_tready low) freezes the whole pipeline in place
// reset clears the valid bits only; the datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_luminance_lerp_xyz_to_rgb_macros.svh"

module keyframe_luminance_lerp_xyz_to_rgb #(
  parameter int SUN_KEYS  = kflerp_pkg::SUN_KEYS_DEF,
  parameter int SKY_KEYS  = kflerp_pkg::SKY_KEYS_DEF,
  parameter int FRAC_BITS = kflerp_pkg::FRAC_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // hour [15:0]
  input  wire  [kflerp_pkg::HOUR_W-1:0]            s_tdata,
  input  wire                                      s_tvalid,
  output logic                                     s_tready,
  // sun_red, sun_green, sun_blue, sky_cie_x, sky_cie_y, sky_cie_z,
  // sky_red, sky_green, sky_blue; 24 bits each from the lowest bit up
  output logic [kflerp_pkg::DATA_OUT_W-1:0]        m_tdata,
  output logic                                     m_tvalid,
  input  wire                                      m_tready
);

  localparam int V_W   = FRAC_BITS + 5;
  localparam int OUT_W = kflerp_pkg::OUT_W;
  localparam int SAT_W = ((V_W > OUT_W) ? V_W : OUT_W) + 1;
  localparam int DLY   = 5;

  logic ce;
  logic sun_xyz_v, sky_xyz_v, sun_rgb_v, sky_rgb_v;
  logic signed [V_W-1:0]   sun_xyz [3];
  logic signed [V_W-1:0]   sky_xyz [3];
  logic signed [OUT_W-1:0] sun_rgb [3];
  logic signed [OUT_W-1:0] sky_rgb [3];
  logic signed [OUT_W-1:0] cie_dly [DLY][3];

  // pipeline advances unless a finished word is held by the sink
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  kflerp_interp #(
    .IS_SKY    (1'b0),
    .KEYS      (SUN_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sun_interp (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .hour      (s_tdata),
    .out_valid (sun_xyz_v),
    .xyz       (sun_xyz)
  );

  kflerp_interp #(
    .IS_SKY    (1'b1),
    .KEYS      (SKY_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sky_interp (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .hour      (s_tdata),
    .out_valid (sky_xyz_v),
    .xyz       (sky_xyz)
  );

  kflerp_rgb #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sun_rgb (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sun_xyz_v),
    .xyz       (sun_xyz),
    .out_valid (sun_rgb_v),
    .rgb       (sun_rgb)
  );

  kflerp_rgb #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sky_rgb (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sky_xyz_v),
    .xyz       (sky_xyz),
    .out_valid (sky_rgb_v),
    .rgb       (sky_rgb)
  );

  // clamp an interpolated value to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [V_W-1:0] x);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(x);
    if (w > SAT_W'(kflerp_pkg::OUT_MAX)) return kflerp_pkg::OUT_MAX;
    if (w < SAT_W'(kflerp_pkg::OUT_MIN)) return kflerp_pkg::OUT_MIN;
    return OUT_W'(w);
  endfunction

  // sky xyz delay line, matched to the matrix stages
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        cie_dly[0][c] <= sat_out(sky_xyz[c]);
        for (int s = 1; s < DLY; s++) cie_dly[s][c] <= cie_dly[s-1][c];
      end
    end
  end

  // output word
  assign m_tvalid = sun_rgb_v && sky_rgb_v;
  assign m_tdata  = {sky_rgb[2], sky_rgb[1], sky_rgb[0],
                     cie_dly[DLY-1][2], cie_dly[DLY-1][1], cie_dly[DLY-1][0],
                     sun_rgb[2], sun_rgb[1], sun_rgb[0]};

  `KFLERP_ASSERT_NOW(a_valid_lockstep, clk, rst, sun_xyz_v || sky_xyz_v || sun_rgb_v || sky_rgb_v,
    (sun_xyz_v == sky_xyz_v) && (sun_rgb_v == sky_rgb_v), "top: sun and sky pipes out of step")
  `KFLERP_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready,
    "top: input blocked with no result pending")
  `KFLERP_ASSERT_NEXT(a_stall_freezes_delay, clk, rst, m_tvalid && !m_tready,
    $stable(cie_dly[DLY-1][0]) && $stable(cie_dly[0][0]), "top: delay line moved during stall")

endmodule

`default_nettype wire

// ===== hw/rtl/kflerp_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_luminance_lerp_xyz_to_rgb_macros.svh"

module kflerp_interp #(
  parameter bit IS_SKY    = 1'b0,
  parameter int KEYS      = kflerp_pkg::SUN_KEYS_DEF,
  parameter int FRAC_BITS = kflerp_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   ce,
  input  wire                                   in_valid,
  input  wire        [kflerp_pkg::HOUR_W-1:0]   hour,
  output logic                                  out_valid,
  output logic signed [FRAC_BITS+4:0]           xyz [3]
);

  localparam int ROM   = IS_SKY ? kflerp_pkg::SKY_ROM : kflerp_pkg::SUN_ROM;
  localparam int N     = (KEYS > ROM) ? ROM : ((KEYS < 1) ? 1 : KEYS);
  localparam int IDX_W = $clog2(ROM);
  localparam int UP_W  = $clog2(ROM + 1);
  localparam int V_W   = FRAC_BITS + 5;
  localparam int D_W   = V_W + 1;
  localparam int T_W   = kflerp_pkg::T_W;
  localparam int SH_W  = kflerp_pkg::SH_W;
  localparam int P_W   = D_W + T_W + 1;
  localparam int HW    = kflerp_pkg::HOUR_W;

  // constant keyframe tables
  logic        [HW-1:0]   key_tab [ROM];
  logic        [SH_W-1:0] sh_tab  [ROM];
  logic signed [V_W-1:0]  val_tab [ROM][3];

  for (genvar i = 0; i < ROM; i++) begin : g_rom
    localparam int KH = kflerp_pkg::key_hour(IS_SKY, i);
    localparam int SH = kflerp_pkg::span_shift(IS_SKY, i, ROM);
    assign key_tab[i] = HW'(KH << kflerp_pkg::HOUR_FRAC);
    assign sh_tab[i]  = SH_W'(SH);
    for (genvar c = 0; c < 3; c++) begin : g_comp
      localparam longint FX = kflerp_pkg::to_fixed(
        IS_SKY ? longint'(kflerp_pkg::sky_val(i, c)) : longint'(kflerp_pkg::sun_val(i, c)),
        FRAC_BITS);
      assign val_tab[i][c] = V_W'(FX);
    end
  end

  logic [3:0] v;

  // stage 1: key search, neighbor indexes and offset into the span
  logic [IDX_W-1:0] s1_lo_idx, s1_hi_idx;
  logic [T_W-1:0]   s1_t;
  logic [SH_W-1:0]  s1_sh;
  logic [IDX_W-1:0] lo_idx_next, hi_idx_next;
  logic [T_W-1:0]   t_next;
  logic [SH_W-1:0]  sh_next;

  always_comb begin
    logic [UP_W-1:0] up;
    up = UP_W'(N);
    for (int i = N - 1; i >= 0; i--) begin
      if (hour < key_tab[i]) up = UP_W'(i);
    end
    if (up == '0) begin
      lo_idx_next = '0;
      hi_idx_next = '0;
      t_next      = '0;
      sh_next     = SH_W'(kflerp_pkg::HOUR_FRAC);
    end else if (up == UP_W'(N)) begin
      lo_idx_next = IDX_W'(N - 1);
      hi_idx_next = IDX_W'(N - 1);
      t_next      = '0;
      sh_next     = SH_W'(kflerp_pkg::HOUR_FRAC);
    end else begin
      lo_idx_next = IDX_W'(up - 1'b1);
      hi_idx_next = IDX_W'(up);
      t_next      = T_W'(hour - key_tab[IDX_W'(up - 1'b1)]);
      sh_next     = sh_tab[IDX_W'(up - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_lo_idx <= lo_idx_next;
      s1_hi_idx <= hi_idx_next;
      s1_t      <= t_next;
      s1_sh     <= sh_next;
    end
  end

  // stage 2: table read and difference
  logic signed [V_W-1:0] s2_lo   [3];
  logic signed [D_W-1:0] s2_diff [3];
  logic [T_W-1:0]        s2_t;
  logic [SH_W-1:0]       s2_sh;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        s2_lo[c]   <= val_tab[s1_lo_idx][c];
        s2_diff[c] <= D_W'(val_tab[s1_hi_idx][c]) - D_W'(val_tab[s1_lo_idx][c]);
      end
      s2_t  <= s1_t;
      s2_sh <= s1_sh;
    end
  end

  // stage 3: difference times offset
  logic signed [V_W-1:0] s3_lo   [3];
  logic signed [P_W-1:0] s3_prod [3];
  logic [SH_W-1:0]       s3_sh;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        s3_lo[c]   <= s2_lo[c];
        s3_prod[c] <= P_W'(s2_diff[c]) * P_W'($signed({1'b0, s2_t}));
      end
      s3_sh <= s2_sh;
    end
  end

  // stage 4: divide by the power-of-two span, round half away from zero, add base
  logic signed [V_W-1:0] xyz_next [3];

  always_comb begin
    logic [P_W-1:0]        mag  [3];
    logic [P_W-1:0]        rq   [3];
    logic signed [P_W-1:0] adj  [3];
    logic [P_W-1:0]        half;
    half = P_W'(1) << (s3_sh - 1'b1);
    for (int c = 0; c < 3; c++) begin
      mag[c] = s3_prod[c][P_W-1] ? P_W'(-s3_prod[c]) : P_W'(s3_prod[c]);
      rq[c]  = (mag[c] + half) >> s3_sh;
      adj[c] = s3_prod[c][P_W-1] ? -$signed(rq[c]) : $signed(rq[c]);
      xyz_next[c] = V_W'(P_W'(s3_lo[c]) + adj[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) xyz[c] <= xyz_next[c];
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[2:0], in_valid};
    end
  end

  assign out_valid = v[3];

  `KFLERP_ASSERT_NOW(a_idx_adjacent, clk, rst, v[0],
    (s1_hi_idx == s1_lo_idx) || (s1_hi_idx == IDX_W'(s1_lo_idx + 1'b1)),
    "interp: neighbor keys not adjacent")
  `KFLERP_ASSERT_NOW(a_clamp_no_offset, clk, rst, v[0] && (s1_hi_idx == s1_lo_idx),
    s1_t == '0, "interp: clamped lookup carries an offset")
  `KFLERP_ASSERT_NOW(a_offset_in_span, clk, rst, v[0],
    (T_W + 1)'(s1_t) < ((T_W + 1)'(1) << s1_sh), "interp: offset beyond span")

endmodule

`default_nettype wire

// ===== hw/rtl/kflerp_rgb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kflerp_rgb #(
  parameter int FRAC_BITS = kflerp_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   ce,
  input  wire                                   in_valid,
  input  wire signed [FRAC_BITS+4:0]            xyz [3],
  output logic                                  out_valid,
  output logic signed [kflerp_pkg::OUT_W-1:0]   rgb [3]
);

  localparam int V_W     = FRAC_BITS + 5;
  localparam int C_W     = kflerp_pkg::C_W;
  localparam int PR_W    = V_W + C_W;
  localparam int S_W     = PR_W + 2;
  localparam int CMP_W   = (S_W + 1 > kflerp_pkg::CAP_W) ? S_W + 1 : kflerp_pkg::CAP_W;
  localparam int DQ_W    = kflerp_pkg::DQ_W;
  localparam int PRE     = kflerp_pkg::DIV_PRE_SH;
  localparam int LO_W    = kflerp_pkg::PP_LO_W;
  localparam int DH_W    = kflerp_pkg::DQ_HI_W;
  localparam int RH_W    = kflerp_pkg::RC_HI_W;
  localparam int FULL_W  = kflerp_pkg::FULL_W;
  localparam int QUOT_W  = kflerp_pkg::QUOT_W;
  localparam int OUT_W   = kflerp_pkg::OUT_W;
  localparam int RSH     = kflerp_pkg::RECIP_SH;

  localparam logic [kflerp_pkg::RECIP_W-1:0] RECIP_V = kflerp_pkg::RECIP_W'(kflerp_pkg::RECIP);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP_V[LO_W-1:0];
  localparam logic [RH_W-1:0] RECIP_HI = RECIP_V[kflerp_pkg::RECIP_W-1:LO_W];

  // constant matrix
  logic signed [C_W-1:0] coef_tab [3][3];
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int CF = kflerp_pkg::mat_coef(r, c);
      assign coef_tab[r][c] = C_W'(CF);
    end
  end

  logic [4:0] v;

  // stage 1: nine products
  logic signed [PR_W-1:0] p1 [3][3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1[r][c] <= PR_W'(xyz[c]) * PR_W'(coef_tab[r][c]);
        end
      end
    end
  end

  // stage 2: row sums
  logic signed [S_W-1:0] sum2 [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        sum2[r] <= S_W'(p1[r][0]) + S_W'(p1[r][1]) + S_W'(p1[r][2]);
      end
    end
  end

  // stage 3: magnitude plus half, saturation check, pre-shift for the divide
  logic             neg3 [3];
  logic             sat3 [3];
  logic [DQ_W-1:0]  dq3  [3];
  always_comb begin
    logic [S_W-1:0]   mag  [3];
    logic [CMP_W-1:0] mag2 [3];
    for (int r = 0; r < 3; r++) begin
      mag[r]  = sum2[r][S_W-1] ? S_W'(-sum2[r]) : S_W'(sum2[r]);
      mag2[r] = CMP_W'(mag[r]) + CMP_W'(kflerp_pkg::HALF_MICRO);
      sat3[r] = mag2[r] >= CMP_W'(kflerp_pkg::SAT_CAP);
      neg3[r] = sum2[r][S_W-1];
      dq3[r]  = mag2[r][DQ_W+PRE-1:PRE];
    end
  end

  logic            neg4 [3];
  logic            sat4 [3];
  logic [DQ_W-1:0] dq4  [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        neg4[r] <= neg3[r];
        sat4[r] <= sat3[r];
        dq4[r]  <= dq3[r];
      end
    end
  end

  // stage 4: reciprocal multiply split into four partial products
  logic                 neg5   [3];
  logic                 sat5   [3];
  logic [2*LO_W-1:0]    pp_ll  [3];
  logic [LO_W+RH_W-1:0] pp_lh  [3];
  logic [DH_W+LO_W-1:0] pp_hl  [3];
  logic [DH_W+RH_W-1:0] pp_hh  [3];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        neg5[r]  <= neg4[r];
        sat5[r]  <= sat4[r];
        pp_ll[r] <= (2*LO_W)'(dq4[r][LO_W-1:0]) * (2*LO_W)'(RECIP_LO);
        pp_lh[r] <= (LO_W+RH_W)'(dq4[r][LO_W-1:0]) * (LO_W+RH_W)'(RECIP_HI);
        pp_hl[r] <= (DH_W+LO_W)'(dq4[r][DQ_W-1:LO_W]) * (DH_W+LO_W)'(RECIP_LO);
        pp_hh[r] <= (DH_W+RH_W)'(dq4[r][DQ_W-1:LO_W]) * (DH_W+RH_W)'(RECIP_HI);
      end
    end
  end

  // stage 5: combine, take the quotient, apply sign and saturate
  logic signed [OUT_W-1:0] rgb_next [3];
  always_comb begin
    logic [FULL_W-1:0] full [3];
    logic [QUOT_W-1:0] q    [3];
    for (int r = 0; r < 3; r++) begin
      full[r] = (FULL_W'(pp_hh[r]) << (2 * LO_W))
              + ((FULL_W'(pp_lh[r]) + FULL_W'(pp_hl[r])) << LO_W)
              + FULL_W'(pp_ll[r]);
      q[r] = full[r][RSH+QUOT_W-1:RSH];
      if (sat5[r]) begin
        rgb_next[r] = neg5[r] ? kflerp_pkg::OUT_MIN : kflerp_pkg::OUT_MAX;
      end else if (!neg5[r] && q[r][QUOT_W-1]) begin
        rgb_next[r] = kflerp_pkg::OUT_MAX;
      end else begin
        rgb_next[r] = neg5[r] ? OUT_W'(-q[r]) : OUT_W'(q[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) rgb[r] <= rgb_next[r];
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[3:0], in_valid};
    end
  end

  assign out_valid = v[4];

endmodule

`default_nettype wire
